/* hw/rtl/mexp_pkg.sv */
package mexp_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_BITS = $clog2(WORD_BITS);
	localparam int CFG_IDX_BITS = 1;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_EXPONENT = cfg_idx_t'(0);
	localparam cfg_idx_t REG_MODULUS = cfg_idx_t'(1);

	localparam word_t EXPONENT_RESET = word_t'(1);
	localparam word_t MODULUS_RESET = '1;

	// request to the shared modular multiplier: a * b mod m, with a < m
	typedef struct packed {
		logic start;
		word_t a;
		word_t b;
		word_t m;
	} mm_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		word_t result;
	} mm_rsp_t;

endpackage

/* hw/rtl/mexp_if.sv */
interface mexp_base_if;
	import mexp_pkg::*;

	logic valid;
	logic ready;
	word_t base_value;

	modport source (output valid, output base_value, input ready);
	modport sink (input valid, input base_value, output ready);
endinterface

interface mexp_result_if;
	import mexp_pkg::*;

	logic valid;
	logic ready;
	word_t power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

/* hw/rtl/mexp_mulmod.sv */
module mexp_mulmod (
	input  logic              clk,
	input  logic              arst_n,
	input  mexp_pkg::mm_req_t req,
	output mexp_pkg::mm_rsp_t rsp
);
	import mexp_pkg::*;

	word_t a_q;
	word_t b_q;
	word_t m_q;
	word_t acc_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	word_t room_d;
	word_t dbl;
	word_t room_a;
	word_t sum_a;
	word_t nxt;

	// one multiplier bit per cycle, MSB first: acc = 2*acc (+ a) mod m
	always_comb begin
		room_d = m_q - acc_q;
		dbl = (acc_q >= room_d) ? (acc_q - room_d) : (acc_q + acc_q);
		room_a = m_q - a_q;
		sum_a = (dbl >= room_a) ? (dbl - room_a) : (dbl + a_q);
		nxt = b_q[WORD_BITS-1] ? sum_a : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_BITS'(WORD_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			m_q <= req.m;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= nxt;
			b_q <= {b_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.result = acc_q;

endmodule

/* hw/rtl/modular_exponentiation.sv */
// Per block: one modular product for the base reduction, one square per exponent
// bit below the top set bit and one multiply per set bit, then a load of the
// output register. One block at a time, a new beat only while the sequencer is idle;
// the shared shift-and-add multiplier sets the pace, a held result stalls the input.
// Reset: exponent returns to 1, modulus to all ones, sequencer idle, no result.
module modular_exponentiation (
	input  logic                     clk,
	input  logic                     arst_n,
	mexp_base_if.sink                base_ch,
	mexp_result_if.source            result_ch,
	input  logic                     cfg_we,
	input  mexp_pkg::cfg_idx_t       cfg_index,
	input  mexp_pkg::word_t          cfg_data
);
	import mexp_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_REDUCE = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_SQR    = 3'd3;
	localparam logic [2:0] S_OUT    = 3'd4;

	word_t exponent_q;
	word_t modulus_q;

	logic [2:0] state_q, state_d;
	logic start_q, start_d;
	word_t req_a_q, req_a_d;
	word_t req_b_q, req_b_d;
	word_t m_q, m_d;
	word_t exp_q, exp_d;
	word_t r_q, r_d;
	word_t base_q, base_d;
	logic out_valid_q;
	word_t out_data_q;
	logic load;

	word_t m_eff;
	word_t one_mod;

	mm_req_t mm_req;
	mm_rsp_t mm_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= EXPONENT_RESET;
			modulus_q <= MODULUS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPONENT: exponent_q <= cfg_data;
				REG_MODULUS:  modulus_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero modulus acts as one
	assign m_eff = (modulus_q == '0) ? word_t'(1) : modulus_q;
	assign one_mod = (m_eff == word_t'(1)) ? '0 : word_t'(1);

	always_comb begin
		state_d = state_q;
		start_d = 1'b0;
		req_a_d = req_a_q;
		req_b_d = req_b_q;
		m_d = m_q;
		exp_d = exp_q;
		r_d = r_q;
		base_d = base_q;
		load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (base_ch.valid) begin
					// reduce the base as 1 * base mod m
					m_d = m_eff;
					exp_d = exponent_q;
					r_d = one_mod;
					start_d = 1'b1;
					req_a_d = one_mod;
					req_b_d = base_ch.base_value;
					state_d = S_REDUCE;
				end
			end
			S_REDUCE: begin
				if (mm_rsp.done) begin
					base_d = mm_rsp.result;
					if (exp_q == '0) begin
						state_d = S_OUT;
					end else if (exp_q[0]) begin
						start_d = 1'b1;
						req_a_d = r_q;
						req_b_d = mm_rsp.result;
						state_d = S_MUL;
					end else begin
						start_d = 1'b1;
						req_a_d = mm_rsp.result;
						req_b_d = mm_rsp.result;
						state_d = S_SQR;
					end
				end
			end
			S_MUL: begin
				if (mm_rsp.done) begin
					r_d = mm_rsp.result;
					// drop the remaining squares once no exponent bit is left
					if (exp_q[WORD_BITS-1:1] == '0) begin
						state_d = S_OUT;
					end else begin
						start_d = 1'b1;
						req_a_d = base_q;
						req_b_d = base_q;
						state_d = S_SQR;
					end
				end
			end
			S_SQR: begin
				if (mm_rsp.done) begin
					base_d = mm_rsp.result;
					exp_d = exp_q >> 1;
					start_d = 1'b1;
					if (exp_q[1]) begin
						req_a_d = r_q;
						req_b_d = mm_rsp.result;
						state_d = S_MUL;
					end else begin
						req_a_d = mm_rsp.result;
						req_b_d = mm_rsp.result;
						state_d = S_SQR;
					end
				end
			end
			S_OUT: begin
				// hold until the output register frees up
				if (!out_valid_q || result_ch.ready) begin
					load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= start_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_a_q <= req_a_d;
		req_b_q <= req_b_d;
		m_q <= m_d;
		exp_q <= exp_d;
		r_q <= r_d;
		base_q <= base_d;
		if (load) begin
			out_data_q <= r_q;
		end
	end

	assign mm_req.start = start_q;
	assign mm_req.a = req_a_q;
	assign mm_req.b = req_b_q;
	assign mm_req.m = m_q;

	mexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	assign base_ch.ready = (state_q == S_IDLE);
	assign result_ch.valid = out_valid_q;
	assign result_ch.power_result = out_data_q;

	a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mm_rsp.busy && !start_q)
		else $error("multiplier active while sequencer idle");

	a_done_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> (state_q == S_REDUCE || state_q == S_MUL || state_q == S_SQR))
		else $error("multiplier done outside a working state");

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_SQR || state_q == S_OUT) |-> (r_q < m_q))
		else $error("partial result not below modulus");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q && (out_data_q == $past(r_q)))
		else $error("result register not loaded");

endmodule

/* dv/tb_modular_exponentiation.sv */
module tb_modular_exponentiation;
	timeunit 1ns;
	timeprecision 1ps;

	import mexp_pkg::*;

	localparam int RESET_CYCLES = 5;
	localparam int TAIL_CYCLES = 2400;
	localparam int STALL_LIMIT = 25000;
	localparam int HOLD_OFF_CYCLES = 6000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		word_t base;
		word_t power;
	} expected_power_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	word_t cfg_data;

	mexp_base_if base_ch ();
	mexp_result_if result_ch ();

	modular_exponentiation u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.base_ch(base_ch),
		.result_ch(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// local copy of the block's registers
	word_t exponent_cfg;
	word_t modulus_cfg;

	expected_power_t expected_powers[$];
	int fail_count;
	int stall_cycles;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;

	always #10 clk = ~clk;

	// square-and-multiply with full-width products
	function automatic word_t power_mod(word_t base);
		logic [63:0] m;
		logic [63:0] b;
		logic [63:0] r;
		m = (modulus_cfg == '0) ? 64'd1 : {32'd0, modulus_cfg};
		b = {32'd0, base} % m;
		r = 64'd1 % m;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (exponent_cfg[i])
				r = (r * b) % m;
			b = (b * b) % m;
		end
		return word_t'(r);
	endfunction

	// random value with its top bit at position bits-1
	function automatic word_t random_of_width(int bits);
		word_t v;
		v = $urandom;
		v = v >> (WORD_BITS - bits);
		v[bits-1] = 1'b1;
		return v;
	endfunction

	task automatic report_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// entered and left at a falling edge; valid stays up for the next beat
	task automatic send_block(word_t value);
		expected_power_t exp_item;
		while ($urandom_range(99) < send_idle_pct) begin
			base_ch.valid <= 1'b0;
			@(negedge clk);
		end
		base_ch.valid <= 1'b1;
		base_ch.base_value <= value;
		do @(posedge clk); while (!base_ch.ready);
		exp_item.base = value;
		exp_item.power = power_mod(value);
		expected_powers.insert(expected_powers.size(), exp_item);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		base_ch.valid <= 1'b0;
		while (expected_powers.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_config(word_t exponent, word_t modulus);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= REG_EXPONENT;
		cfg_data <= exponent;
		@(negedge clk);
		cfg_index <= REG_MODULUS;
		cfg_data <= modulus;
		@(negedge clk);
		cfg_we <= 1'b0;
		exponent_cfg = exponent;
		modulus_cfg = modulus;
	endtask

	task automatic random_config();
		word_t e;
		word_t m;
		case ($urandom_range(7))
			0: e = '0;
			1: e = word_t'(1);
			2: e = '1;
			default: e = random_of_width($urandom_range(1, WORD_BITS));
		endcase
		case ($urandom_range(7))
			0: m = word_t'(1);
			1: m = '1;
			2: m = word_t'(2);
			default: m = random_of_width($urandom_range(2, WORD_BITS));
		endcase
		set_config(e, m);
	endtask

	function automatic word_t random_base();
		case ($urandom_range(6))
			0: return word_t'($urandom_range(255));
			1: return modulus_cfg - word_t'($urandom_range(2));
			2: return modulus_cfg + word_t'($urandom_range(3));
			3: return $urandom_range(1) ? '1 : '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_reset_values();
		send_block('0);
		send_block(word_t'(1));
		send_block(32'hFFFF_FFFE);
		send_block('1);
		send_block(32'h8000_0000);
	endtask

	task automatic test_corner_configs();
		// zero exponent gives one reduced by the modulus
		set_config('0, word_t'(7));
		send_block('0);
		send_block(word_t'(5));
		send_block('1);
		set_config('1, '1);
		send_block(word_t'(2));
		send_block(32'hFFFF_FFFE);
		send_block(32'h1234_5678);
		set_config(32'hDEAD_BEEF, word_t'(1));
		send_block('0);
		send_block('1);
		// exponent one still reduces the base
		set_config(word_t'(1), 32'h8000_0000);
		send_block('1);
		set_config(word_t'(1), word_t'(13));
		send_block(word_t'(100));
		set_config(word_t'(65537), 32'hFFFF_FFFB);
		send_block(32'hAAAA_AAAA);
		send_block(32'h5555_5555);
		set_config(32'h8000_0000, 32'h7FFF_FFFF);
		send_block(word_t'(3));
	endtask

	task automatic test_random_blocks(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 20 == 0)
				random_config();
			send_block(random_base());
		end
	endtask

	// hold the output off long enough that the block stalls its input
	task automatic test_output_hold_off();
		random_config();
		hold_left = HOLD_OFF_CYCLES;
		for (int i = 0; i < 6; i++)
			send_block(random_base());
	endtask

	task automatic test_drain_pause();
		random_config();
		for (int i = 0; i < 4; i++)
			send_block(random_base());
		wait_drained();
		for (int i = 0; i < 4; i++)
			send_block(random_base());
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		expected_power_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_powers.size() == 0) begin
				report_failure($sformatf("unexpected power_result %h", result_ch.power_result));
			end else begin
				want = expected_powers.pop_front();
				if (result_ch.power_result !== want.power)
					report_failure($sformatf("power_result mismatch: base %h exp %h mod %h expected %h got %h",
						want.base, exponent_cfg, modulus_cfg, want.power, result_ch.power_result));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (base_ch.valid && base_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_EXPONENT;
		cfg_data = '0;
		base_ch.valid = 1'b0;
		base_ch.base_value = '0;
		result_ch.ready = 1'b0;
		exponent_cfg = EXPONENT_RESET;
		modulus_cfg = MODULUS_RESET;
		fail_count = 0;
		stall_cycles = 0;
		hold_left = 0;
		send_idle_pct = 14;
		recv_idle_pct = 72;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_corner_configs();
		test_random_blocks(80);
		test_output_hold_off();
		send_idle_pct = 72;
		recv_idle_pct = 14;
		test_random_blocks(80);
		test_drain_pause();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_blocks(80);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
